// ===== sv/coo_sparse_matvec_accumulate_top_macros.svh =====
`ifndef COO_SPARSE_MATVEC_ACCUMULATE_TOP_MACROS_SVH
`define COO_SPARSE_MATVEC_ACCUMULATE_TOP_MACROS_SVH

// same-cycle implication, disabled while active-low reset is asserted
`define CSMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csma: check failed");

// next-cycle implication, disabled while active-low reset is asserted
`define CSMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csma: check failed");

`endif

// ===== sv/csma_pkg.sv =====
package csma_pkg;

    localparam int FUNC_W        = 2;
    localparam int IDX_W         = 10;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int FRAC_W        = 16;
    localparam int SHIFT_W       = PROD_W - FRAC_W;
    localparam int CFG_IDX_W     = 1;
    localparam int CMP_W         = 17;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [FUNC_W-1:0] F_WR_X = 2'd0;
    localparam logic [FUNC_W-1:0] F_LD_B = 2'd1;
    localparam logic [FUNC_W-1:0] F_ACC  = 2'd2;
    localparam logic [FUNC_W-1:0] F_RD_B = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 1'b1;

    localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] BETA_RESET  = 32'h0000_0000;
    localparam logic [DATA_W-1:0] SAT_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] value;
    } t_sat;

    // shifted product, saturate to 32 bits
    function automatic t_sat sat_prod(input logic [SHIFT_W-1:0] v);
        t_sat r;
        logic [SHIFT_W-DATA_W:0] top;
        top = v[SHIFT_W-1:DATA_W-1];
        r.ovf = !((&top) || (~|top));
        r.value = r.ovf ? (v[SHIFT_W-1] ? SAT_MIN : SAT_MAX) : v[DATA_W-1:0];
        return r;
    endfunction

    // 33-bit sum, saturate to 32 bits
    function automatic t_sat sat_sum(input logic [DATA_W:0] v);
        t_sat r;
        r.ovf = v[DATA_W] ^ v[DATA_W-1];
        r.value = r.ovf ? (v[DATA_W] ? SAT_MIN : SAT_MAX) : v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/coo_sparse_matvec_accumulate_top.sv =====
// COO sparse matrix-vector engine, b = beta*b + alpha*A*x in signed Q16.16, with x and b
// held in two synchronous-read RAMs of VECTOR_DEPTH words.
// Requests are handled one at a time: write x completes when accepted; read b waits while
// the result register is still held; load b makes one pass through the one shared 32x32
// multiplier and a saturation stage; accumulate nonzero makes two dependent passes through
// it, each followed by a saturation stage, and then the add to the stored b entry.
// Products are shifted right arithmetically by 16; every saturation sets a sticky flag that
// is returned with each read. Requests with an index at or past VECTOR_DEPTH are dropped,
// and a read of such an index returns zero. Memory contents are undefined until written.
`include "coo_sparse_matvec_accumulate_top_macros.svh"

module coo_sparse_matvec_accumulate_top #(
    parameter int VECTOR_DEPTH = csma_pkg::DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [csma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [csma_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [csma_pkg::FUNC_W-1:0]    i_func,
    input  logic [csma_pkg::IDX_W-1:0]     i_row_index,
    input  logic [csma_pkg::IDX_W-1:0]     i_col_index,
    input  logic signed [csma_pkg::DATA_W-1:0] i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [csma_pkg::IDX_W-1:0]     o_read_index,
    output logic signed [csma_pkg::DATA_W-1:0] o_read_value,
    output logic                           o_overflow_seen
);
    import csma_pkg::*;

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_SAT1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_SAT2  = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;

    logic [DATA_W-1:0] x_mem [VECTOR_DEPTH];
    logic [DATA_W-1:0] b_mem [VECTOR_DEPTH];

    logic [2:0]        r_state, n_state;
    logic [DATA_W-1:0] r_alpha, r_beta;
    logic              r_sticky, n_sticky;
    logic [FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]  r_row;
    logic [AW-1:0]     r_row_addr;
    logic              r_row_ok;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_x_rd, r_b_rd;
    logic [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0] r_t1, r_t2;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_ovf;

    logic              w_in_acc;
    logic              w_row_ok, w_col_ok;
    logic [AW-1:0]     w_row_addr, w_col_addr;
    logic              w_x_we, w_b_we;
    logic [DATA_W-1:0] w_b_wdata;
    logic [DATA_W-1:0] w_mul_a, w_mul_b;
    logic [DATA_W:0]   w_sum;
    t_sat              w_sat1, w_sat2, w_sat3;
    logic              w_out_load;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_row_ok   = CMP_W'(i_row_index) < CMP_W'(VECTOR_DEPTH);
    assign w_col_ok   = CMP_W'(i_col_index) < CMP_W'(VECTOR_DEPTH);
    assign w_row_addr = AW'(CMP_W'(i_row_index));
    assign w_col_addr = AW'(CMP_W'(i_col_index));

    assign w_x_we = w_in_acc && (i_func == F_WR_X) && w_row_ok;

    assign w_mul_a = (r_state == S_MUL2) ? r_t1 : ((r_func == F_LD_B) ? r_beta : r_alpha);
    assign w_mul_b = (r_state == S_MUL2) ? r_x_rd : r_value;

    assign w_sat1 = sat_prod(r_prod[PROD_W-1:FRAC_W]);
    assign w_sat2 = sat_prod(r_prod[PROD_W-1:FRAC_W]);
    assign w_sum  = {r_b_rd[DATA_W-1], r_b_rd} + {r_t2[DATA_W-1], r_t2};
    assign w_sat3 = sat_sum(w_sum);

    assign w_b_we    = ((r_state == S_SAT1) && (r_func == F_LD_B)) || (r_state == S_ADD);
    assign w_b_wdata = (r_state == S_SAT1) ? w_sat1.value : w_sat3.value;

    assign w_out_load = (r_state == S_SCALE) && (r_func == F_RD_B)
                        && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (w_x_we) begin
            x_mem[w_row_addr] <= i_value;
        end
        if (w_in_acc) begin
            r_x_rd <= x_mem[w_col_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            b_mem[r_row_addr] <= w_b_wdata;
        end
        if (w_in_acc) begin
            r_b_rd <= b_mem[w_row_addr];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_sticky = r_sticky;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_func)
                        F_RD_B: n_state = S_SCALE;
                        F_LD_B: n_state = w_row_ok ? S_SCALE : S_IDLE;
                        F_ACC:  n_state = (w_row_ok && w_col_ok) ? S_SCALE : S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCALE: begin
                if (r_func == F_RD_B) begin
                    n_state = w_out_load ? S_IDLE : S_SCALE;
                end else begin
                    n_state = S_SAT1;
                end
            end
            S_SAT1: begin
                n_sticky = r_sticky | w_sat1.ovf;
                n_state  = (r_func == F_ACC) ? S_MUL2 : S_IDLE;
            end
            S_MUL2: n_state = S_SAT2;
            S_SAT2: begin
                n_sticky = r_sticky | w_sat2.ovf;
                n_state  = S_ADD;
            end
            S_ADD: begin
                n_sticky = r_sticky | w_sat3.ovf;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sticky <= 1'b0;
            r_alpha  <= ALPHA_RESET;
            r_beta   <= BETA_RESET;
        end else begin
            r_state  <= n_state;
            r_sticky <= n_sticky;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    CFG_BETA:  r_beta  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func     <= i_func;
            r_row      <= i_row_index;
            r_row_addr <= w_row_addr;
            r_row_ok   <= w_row_ok;
            r_value    <= i_value;
        end
        if ((r_state == S_SCALE) || (r_state == S_MUL2)) begin
            r_prod <= PROD_W'($signed(w_mul_a)) * PROD_W'($signed(w_mul_b));
        end
        if (r_state == S_SAT1) begin
            r_t1 <= w_sat1.value;
        end
        if (r_state == S_SAT2) begin
            r_t2 <= w_sat2.value;
        end
        if (w_out_load) begin
            r_out_index <= r_row;
            r_out_value <= r_row_ok ? r_b_rd : '0;
            r_out_ovf   <= r_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_index    = r_out_index;
    assign o_read_value    = r_out_value;
    assign o_overflow_seen = r_out_ovf;

    `CSMA_ASSERT_NEXT(a_sticky_holds, i_clk, i_rst_n, r_sticky, r_sticky)
    `CSMA_ASSERT_NOW(a_b_write_state, i_clk, i_rst_n, w_b_we, (r_state == S_SAT1) || (r_state == S_ADD))
    `CSMA_ASSERT_NEXT(a_read_enters, i_clk, i_rst_n, w_in_acc && (i_func == F_RD_B), r_state == S_SCALE)

endmodule
